FILE: design/bdef_pkg.sv
// ----------------------------------------------------------------------------
// bdef_pkg
// Shared types and constants of the binary diagonal edge filter.
// ----------------------------------------------------------------------------
`default_nettype none

package bdef_pkg;

   // Fixed field widths.
   localparam int ROW_W   = 12;
   localparam int WREG_W  = 8;
   localparam int HREG_W  = 12;
   localparam int CSR_W   = 12;
   localparam int CSR_IDX_W = 1;

   // Number of result slots one item can fill.
   localparam int NUM_SLOTS = 3;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   // Register reset values.
   localparam logic [WREG_W-1:0] WIDTH_RESET  = 8'd128;
   localparam logic [HREG_W-1:0] HEIGHT_RESET = 12'd128;

   // Control handed from the pixel stage to the result emitter.
   typedef struct packed {
      logic                 valid;  // a result set is offered
      logic [NUM_SLOTS-1:0] mask;   // which of the three slots carry a result
      logic                 done;   // the set ends the image
   } emit_ctl_type;

endpackage

`default_nettype wire

FILE: design/binary_diagonal_edge_filter.sv
// ----------------------------------------------------------------------------
// binary_diagonal_edge_filter
// Raster-order binary image filter: an interior pixel whose four diagonal
// neighbors are all set is cleared, every other pixel passes unchanged.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   req_     in         req_valid/req_ready    req_pixel_in
//   rsp_     out        rsp_valid/rsp_ready    rsp_pixel_out, rsp_out_row,
//                                              rsp_out_col, rsp_last_of_run,
//                                              rsp_image_done
//   csr_     in         csr_we (no wait)       csr_index, csr_wdata
//
// An accepted item reads its column of the line memory at once and waits in
// the pixel stage; when it moves on, the window shifts, the column is written
// back and the item's results are handed to the emitter, which registers them.
// The emitter sends one result per cycle while rsp_ready is high, so an item
// with several results (at row ends and on the last row) holds the input
// until its last result leaves; items with at most one result flow at one
// per cycle while rsp_ready is high.
// Reset is synchronous and clears counters, window and handshake state; the
// line memory is not cleared, since an entry is always written before a result
// depends on it.
// A stall on rsp_ backs up through the pixel stage to req_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_diagonal_edge_filter #(
   parameter int MAX_WIDTH = 128
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output      logic                                   req_ready,
   input  wire logic                                   req_pixel_in,
   output      logic                                   rsp_valid,
   input  wire logic                                   rsp_ready,
   output      logic                                   rsp_pixel_out,
   output      logic [bdef_pkg::ROW_W-1:0]             rsp_out_row,
   output      logic [$clog2(MAX_WIDTH)-1:0]           rsp_out_col,
   output      logic                                   rsp_last_of_run,
   output      logic                                   rsp_image_done,
   input  wire logic                                   csr_we,
   input  wire logic [bdef_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [bdef_pkg::CSR_W-1:0]             csr_wdata
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int CMP_W = ($clog2(MAX_WIDTH + 1) > bdef_pkg::WREG_W) ?
                          $clog2(MAX_WIDTH + 1) : bdef_pkg::WREG_W;
   localparam int RW    = bdef_pkg::ROW_W;

   // Configuration registers.
   logic [bdef_pkg::WREG_W-1:0] width_ff;
   logic [bdef_pkg::HREG_W-1:0] height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bdef_pkg::WIDTH_RESET;
         height_ff <= bdef_pkg::HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            bdef_pkg::CSR_IMAGE_WIDTH: begin
               width_ff <= csr_wdata[bdef_pkg::WREG_W-1:0];
            end
            bdef_pkg::CSR_IMAGE_HEIGHT: begin
               height_ff <= csr_wdata[bdef_pkg::HREG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Position of the next pixel and its place in the image.
   logic [RW-1:0]    row_ff, row_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [CMP_W-1:0] width_ext;
   logic [CMP_W-1:0] width_eff;
   logic [CMP_W-1:0] last_col;
   logic [RW-1:0]    last_row_idx;
   logic             row_end;
   logic             last_row;
   logic             accept;

   assign width_ext    = CMP_W'(width_ff);
   assign width_eff    = (width_ff == '0) ? CMP_W'(1) :
                         ((width_ext > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : width_ext);
   assign last_col     = width_eff - CMP_W'(1);
   assign last_row_idx = (height_ff == '0) ? '0 : (height_ff - RW'(1));
   assign row_end      = (CMP_W'(col_ff) >= last_col);
   assign last_row     = (row_ff >= last_row_idx);
   assign accept       = req_valid && req_ready;

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = last_row ? '0 : (row_ff + RW'(1));
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // Pixel stage: the item waits here for its line memory read.
   logic                           s1_valid_ff;
   logic                           s1_pixel_ff;
   logic [RW-1:0]                  s1_row_ff;
   logic [CW-1:0]                  s1_col_ff;
   logic [bdef_pkg::NUM_SLOTS-1:0] s1_mask_ff;
   logic                           s1_interior_ff;
   logic                           s1_done_ff;
   logic                           s1_adv;
   logic                           load_ok;
   logic [bdef_pkg::NUM_SLOTS-1:0] mask_new;

   // Slot 0: filtered pixel up and left; slot 1: right border pixel one row
   // up; slot 2: the pixel itself on the last row.
   assign mask_new[0] = (row_ff != '0) && (col_ff != '0);
   assign mask_new[1] = (row_ff != '0) && row_end;
   assign mask_new[2] = last_row;

   assign s1_adv    = s1_valid_ff && ((s1_mask_ff == '0) || load_ok);
   assign req_ready = !s1_valid_ff || s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff    <= req_pixel_in;
         s1_row_ff      <= row_ff;
         s1_col_ff      <= col_ff;
         s1_mask_ff     <= mask_new;
         s1_interior_ff <= (row_ff[RW-1:1] != '0) && (col_ff[CW-1:1] != '0);
         s1_done_ff     <= last_row && row_end;
      end
   end

   // Line memory: read at acceptance, written back when the item moves on.
   logic [1:0] old_bits;

   bdef_line_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (old_bits),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data ({old_bits[0], s1_pixel_ff})
   );

   logic center_pix;
   logic right_pix;

   bdef_window u_window (
      .clock      (clock),
      .reset      (reset),
      .advance    (s1_adv),
      .old_bits   (old_bits),
      .pixel      (s1_pixel_ff),
      .interior   (s1_interior_ff),
      .center_out (center_pix),
      .right_out  (right_pix)
   );

   // Result set of the item in the pixel stage.
   bdef_pkg::emit_ctl_type                  load_ctl;
   logic [bdef_pkg::NUM_SLOTS-1:0]          load_pixel;
   logic [bdef_pkg::NUM_SLOTS-1:0][RW-1:0]  load_row;
   logic [bdef_pkg::NUM_SLOTS-1:0][CW-1:0]  load_col;

   assign load_ctl.valid = s1_valid_ff && (s1_mask_ff != '0);
   assign load_ctl.mask  = s1_mask_ff;
   assign load_ctl.done  = s1_done_ff;

   assign load_pixel = {s1_pixel_ff, right_pix, center_pix};
   assign load_row   = {s1_row_ff, s1_row_ff - RW'(1), s1_row_ff - RW'(1)};
   assign load_col   = {s1_col_ff, s1_col_ff, s1_col_ff - CW'(1)};

   bdef_emit #(
      .COL_W (CW)
   ) u_emit (
      .clock           (clock),
      .reset           (reset),
      .load_ctl        (load_ctl),
      .load_pixel      (load_pixel),
      .load_row        (load_row),
      .load_col        (load_col),
      .load_ok         (load_ok),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_image_done  (rsp_image_done)
   );

   a_accept_fills : assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted item did not reach the pixel stage");

   a_done_is_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_image_done |-> rsp_last_of_run)
      else $error("image end flagged on a result that is not last of its item");

   a_col_in_range : assert property (@(posedge clock) disable iff (reset)
      CMP_W'(col_ff) < CMP_W'(MAX_WIDTH))
      else $error("column counter beyond the line memory");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_col_ff))
      else $error("stalled pixel stage lost its item");

endmodule

`default_nettype wire

FILE: design/bdef_line_store.sv
// ----------------------------------------------------------------------------
// bdef_line_store
// Line memory holding the two previous rows per column, registered read,
// write-first on a same-address read and write.
// ----------------------------------------------------------------------------
`default_nettype none

module bdef_line_store #(
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  wire logic          clock,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output      logic [1:0]    rd_data,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [1:0]    wr_data
);

   logic [1:0] mem [DEPTH];
   logic [1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         // A write to the same entry in this cycle is passed straight on.
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/bdef_window.sv
// ----------------------------------------------------------------------------
// bdef_window
// 3x3 pixel window and the diagonal filter decision.
// ----------------------------------------------------------------------------
`default_nettype none

module bdef_window (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,
   input  wire logic [1:0] old_bits,   // bit 0 one row up, bit 1 two rows up
   input  wire logic       pixel,
   input  wire logic       interior,
   output      logic       center_out,
   output      logic       right_out
);

   logic [8:0] window_ff;
   logic [8:0] window_in;
   logic [2:0] new_col;

   // Each column slot holds two rows up, one row up and the current row.
   assign new_col   = {pixel, old_bits[0], old_bits[1]};
   assign window_in = {new_col, window_ff[8:3]};

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (advance) begin
         window_ff <= window_in;
      end
   end

   // The center clears when it is interior and all four diagonal neighbors are set.
   assign center_out = window_in[4] &
                       ~(interior & window_in[0] & window_in[2] &
                         window_in[6] & window_in[8]);
   assign right_out  = window_in[7];

endmodule

`default_nettype wire

FILE: design/bdef_emit.sv
// ----------------------------------------------------------------------------
// bdef_emit
// Result emitter: holds the up to three results of one item and sends them
// out one per cycle while rsp_ready is high, in slot order.
// ----------------------------------------------------------------------------
`default_nettype none

module bdef_emit #(
   parameter int COL_W = 7
) (
   input  wire logic                                           clock,
   input  wire logic                                           reset,
   input  wire bdef_pkg::emit_ctl_type                         load_ctl,
   input  wire logic [bdef_pkg::NUM_SLOTS-1:0]                 load_pixel,
   input  wire logic [bdef_pkg::NUM_SLOTS-1:0][bdef_pkg::ROW_W-1:0] load_row,
   input  wire logic [bdef_pkg::NUM_SLOTS-1:0][COL_W-1:0]      load_col,
   output      logic                                           load_ok,
   output      logic                                           rsp_valid,
   input  wire logic                                           rsp_ready,
   output      logic                                           rsp_pixel_out,
   output      logic [bdef_pkg::ROW_W-1:0]                     rsp_out_row,
   output      logic [COL_W-1:0]                               rsp_out_col,
   output      logic                                           rsp_last_of_run,
   output      logic                                           rsp_image_done
);

   logic [bdef_pkg::NUM_SLOTS-1:0]                 mask_ff;
   logic [bdef_pkg::NUM_SLOTS-1:0]                 mask_in;
   logic                                           done_ff;
   logic [bdef_pkg::NUM_SLOTS-1:0]                 pixel_ff;
   logic [bdef_pkg::NUM_SLOTS-1:0][bdef_pkg::ROW_W-1:0] row_ff;
   logic [bdef_pkg::NUM_SLOTS-1:0][COL_W-1:0]      col_ff;
   logic [1:0]                                     sel;
   logic [bdef_pkg::NUM_SLOTS-1:0]                 sel_bit;
   logic                                           single;
   logic                                           fire;
   logic                                           load;

   always_comb begin
      if (mask_ff[0]) begin
         sel = 2'd0;
      end else if (mask_ff[1]) begin
         sel = 2'd1;
      end else begin
         sel = 2'd2;
      end
   end

   assign sel_bit = bdef_pkg::NUM_SLOTS'(1) << sel;
   assign single  = (mask_ff != '0) &&
                    ((mask_ff & (mask_ff - bdef_pkg::NUM_SLOTS'(1))) == '0);
   assign fire    = rsp_valid && rsp_ready;
   assign load_ok = (mask_ff == '0) || (single && rsp_ready);
   assign load    = load_ctl.valid && load_ok;

   always_comb begin
      mask_in = mask_ff;
      if (load) begin
         mask_in = load_ctl.mask;
      end else if (fire) begin
         mask_in = mask_ff & ~sel_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         done_ff  <= load_ctl.done;
         pixel_ff <= load_pixel;
         row_ff   <= load_row;
         col_ff   <= load_col;
      end
   end

   assign rsp_valid       = (mask_ff != '0);
   assign rsp_pixel_out   = pixel_ff[sel];
   assign rsp_out_row     = row_ff[sel];
   assign rsp_out_col     = col_ff[sel];
   assign rsp_last_of_run = single;
   assign rsp_image_done  = single && done_ff;

   a_load_shows : assert property (@(posedge clock) disable iff (reset)
      load && (load_ctl.mask != '0) |=> rsp_valid)
      else $error("loaded result set not presented");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      load |-> (mask_ff == '0) || (single && fire))
      else $error("result set loaded over pending results");

endmodule

`default_nettype wire
